[design/hamming_ball_code_lookup_macros.svh]
// Assertion macros used by the Hamming-ball lookup sequencer.
`ifndef HAMMING_BALL_CODE_LOOKUP_MACROS_SVH
`define HAMMING_BALL_CODE_LOOKUP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define HBL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define HBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hbl_pkg.sv]
// Package with the constants, codes and types of the Hamming-ball lookup.
`timescale 1ns / 1ps
package hbl_pkg;
    localparam int CODE_BITS   = 16;
    localparam int TABLE_DEPTH = 64;
    localparam int IN_CODE_W   = 16;
    localparam int ID_W        = 24;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FLIP_W      = $clog2(CODE_BITS + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REPLY
    } state_t;

    // Word handed along the chain: the flip pattern being searched and the
    // hit flags gathered so far. Each cell shifts its own flag in at the top,
    // so at the end of the chain bit i belongs to cell i.
    typedef struct packed {
        logic                   valid;
        logic                   final_pat;
        logic [CODE_BITS-1:0]   target;
        logic [1:0]             hdist;
        logic [TABLE_DEPTH-1:0] hits;
    } probe_t;
endpackage

[design/hbl_cell.sv]
// One table cell: holds one code and id, compares the probe passing by.
`timescale 1ns / 1ps
module hbl_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [hbl_pkg::CODE_BITS-1:0] wr_code,
    input  logic [hbl_pkg::ID_W-1:0]      wr_id,
    input  logic                          occupied,
    input  logic                          advance,
    input  hbl_pkg::probe_t               probe_in,
    output hbl_pkg::probe_t               probe_out,
    output logic [hbl_pkg::ID_W-1:0]      id_out
);
    logic [hbl_pkg::CODE_BITS-1:0] code_reg;
    logic [hbl_pkg::ID_W-1:0]      id_reg;
    hbl_pkg::probe_t               probe_reg, probe_next;
    logic                          match;

    // Stored entry; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_reg <= wr_code;
            id_reg   <= wr_id;
        end
    end

    // Compare the incoming probe with the stored code and add the flag.
    always_comb
    begin
        match           = probe_in.valid && occupied && (probe_in.target == code_reg);
        probe_next      = probe_in;
        probe_next.hits = {match, probe_in.hits[hbl_pkg::TABLE_DEPTH-1:1]};
    end

    // Probe register handing the pattern to the next cell; the whole row
    // holds while the result side is busy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else if (advance)
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;
    assign id_out    = id_reg;
endmodule

[design/hbl_ctrl.sv]
// Sequencer: command decode, flip enumeration, hit extraction and output register.
`timescale 1ns / 1ps
`include "hamming_ball_code_lookup_macros.svh"
module hbl_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      command,
    input  logic [hbl_pkg::IN_CODE_W-1:0]   code,
    input  logic [hbl_pkg::ID_W-1:0]        entry_id,
    output logic [hbl_pkg::TABLE_DEPTH-1:0] wr_en,
    output logic [hbl_pkg::CODE_BITS-1:0]   wr_code,
    output logic [hbl_pkg::ID_W-1:0]        wr_id,
    output logic [hbl_pkg::TABLE_DEPTH-1:0] occupied,
    output logic                            advance,
    output hbl_pkg::probe_t                 probe,
    input  hbl_pkg::probe_t                 tail,
    input  logic [hbl_pkg::ID_W-1:0]        ids [hbl_pkg::TABLE_DEPTH],
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [hbl_pkg::ID_W-1:0]        match_id,
    output logic [1:0]                      distance,
    output logic                            table_full,
    output logic                            last
);
    localparam int D  = hbl_pkg::TABLE_DEPTH;
    localparam int CB = hbl_pkg::CODE_BITS;

    hbl_pkg::state_t state_reg, state_next;
    logic [hbl_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [CB-1:0]              qcode_reg;
    logic [hbl_pkg::FLIP_W-1:0] j_reg, j_next, k_reg, k_next;
    logic [1:0]                 phase_reg, phase_next;
    logic                       iss_reg, iss_next;
    logic                       full_flag_reg;

    // Pattern word taken from the end of the row, hits still to be sent.
    logic                       ex_valid_reg;
    logic [D-1:0]               ex_vec_reg;
    logic [1:0]                 ex_dist_reg;
    logic                       ex_final_reg;

    // Hit held back until it is known whether another one follows.
    logic                       pend_valid_reg;
    logic [hbl_pkg::ID_W-1:0]   pend_id_reg;
    logic [1:0]                 pend_dist_reg;

    logic                       o_valid_reg;
    logic                       o_found_reg, o_full_reg, o_last_reg;
    logic [hbl_pkg::ID_W-1:0]   o_id_reg;
    logic [1:0]                 o_dist_reg;

    logic                       accept, o_free, take, ex_go, ex_end, o_load, search_done;
    logic [D-1:0]               sel;
    logic [hbl_pkg::ID_W-1:0]   sel_id;
    logic [CB-1:0]              flip_pat;

    assign accept = in_valid && !in_stall;
    assign o_free = !o_valid_reg || !out_stall;

    // Lowest pending hit of the current pattern and its id.
    always_comb
    begin
        sel    = ex_vec_reg & (~ex_vec_reg + D'(1));
        sel_id = '0;
        for (int i = 0; i < D; i++)
        begin
            sel_id = sel_id | ({hbl_pkg::ID_W{sel[i]}} & ids[i]);
        end
    end

    // Current flip pattern: exact, single flip of j, or pair (j,k).
    always_comb
    begin
        flip_pat = '0;
        case (phase_reg)
            2'd1: flip_pat[j_reg[$clog2(CB)-1:0]] = 1'b1;
            2'd2:
            begin
                flip_pat[j_reg[$clog2(CB)-1:0]] = 1'b1;
                flip_pat[k_reg[$clog2(CB)-1:0]] = 1'b1;
            end
            default: flip_pat = '0;
        endcase
    end

    // The single flip of the top bit is the final pattern.
    assign search_done = (phase_reg == 2'd1 && j_reg == hbl_pkg::FLIP_W'(CB - 1));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        iss_next   = iss_reg;
        case (state_reg)
            hbl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (hbl_pkg::cmd_t'(command))
                        hbl_pkg::CMD_CLEAR: count_next = '0;
                        hbl_pkg::CMD_INSERT:
                        begin
                            if (count_reg < hbl_pkg::CNT_W'(D))
                            begin
                                count_next = count_reg + hbl_pkg::CNT_W'(1);
                            end
                            state_next = hbl_pkg::ST_REPLY;
                        end
                        hbl_pkg::CMD_QUERY:
                        begin
                            state_next = hbl_pkg::ST_SEARCH;
                            phase_next = 2'd0;
                            j_next     = '0;
                            k_next     = '0;
                            iss_next   = 1'b1;
                        end
                        default: state_next = hbl_pkg::ST_IDLE;
                    endcase
                end
            end
            hbl_pkg::ST_SEARCH:
            begin
                // Step through patterns in the required order.
                if (iss_reg && advance)
                begin
                    case (phase_reg)
                        2'd0: phase_next = 2'd1;
                        2'd1:
                        begin
                            if (search_done)
                            begin
                                iss_next = 1'b0;
                            end
                            else
                            begin
                                phase_next = 2'd2;
                                k_next     = j_reg + hbl_pkg::FLIP_W'(1);
                            end
                        end
                        default:
                        begin
                            if (k_reg == hbl_pkg::FLIP_W'(CB - 1))
                            begin
                                phase_next = 2'd1;
                                j_next     = j_reg + hbl_pkg::FLIP_W'(1);
                            end
                            else
                            begin
                                k_next = k_reg + hbl_pkg::FLIP_W'(1);
                            end
                        end
                    endcase
                end
                if (ex_end)
                begin
                    state_next = hbl_pkg::ST_REPLY;
                end
            end
            hbl_pkg::ST_REPLY:
            begin
                if (o_free)
                begin
                    state_next = hbl_pkg::ST_IDLE;
                end
            end
            default: state_next = hbl_pkg::ST_IDLE;
        endcase
    end

    // Output-side decisions.
    always_comb
    begin
        in_stall     = (state_reg != hbl_pkg::ST_IDLE);
        take         = !ex_valid_reg || (ex_vec_reg == '0);
        advance      = take || !tail.valid;
        ex_go        = (state_reg == hbl_pkg::ST_SEARCH) && ex_valid_reg
                       && (ex_vec_reg != '0) && (!pend_valid_reg || o_free);
        ex_end       = ex_valid_reg && ex_final_reg && (ex_vec_reg == '0);
        o_load       = (ex_go && pend_valid_reg)
                       || (state_reg == hbl_pkg::ST_REPLY && o_free);
        probe.valid     = (state_reg == hbl_pkg::ST_SEARCH) && iss_reg;
        probe.final_pat = search_done;
        probe.target    = qcode_reg ^ flip_pat;
        probe.hdist     = phase_reg;
        probe.hits      = '0;
        wr_code      = code[CB-1:0];
        wr_id        = entry_id;
        for (int i = 0; i < D; i++)
        begin
            wr_en[i]    = accept && (hbl_pkg::cmd_t'(command) == hbl_pkg::CMD_INSERT)
                          && (count_reg == hbl_pkg::CNT_W'(i));
            occupied[i] = (count_reg > hbl_pkg::CNT_W'(i));
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hbl_pkg::ST_IDLE;
            count_reg      <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            phase_reg      <= '0;
            iss_reg        <= 1'b0;
            ex_valid_reg   <= 1'b0;
            ex_vec_reg     <= '0;
            ex_dist_reg    <= '0;
            ex_final_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
            iss_reg   <= iss_next;
            if (take)
            begin
                ex_valid_reg <= tail.valid;
                ex_vec_reg   <= tail.hits;
                ex_dist_reg  <= tail.hdist;
                ex_final_reg <= tail.final_pat;
            end
            else if (ex_go)
            begin
                ex_vec_reg <= ex_vec_reg & ~sel;
            end
            if (ex_go)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (state_reg == hbl_pkg::ST_REPLY && o_free)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (o_load)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qcode_reg     <= code[CB-1:0];
            full_flag_reg <= (hbl_pkg::cmd_t'(command) == hbl_pkg::CMD_INSERT)
                             && (count_reg >= hbl_pkg::CNT_W'(D));
        end
        if (ex_go)
        begin
            pend_id_reg   <= sel_id;
            pend_dist_reg <= ex_dist_reg;
        end
        if (o_load)
        begin
            if (state_reg == hbl_pkg::ST_REPLY)
            begin
                // Final transaction: the held hit, or the single reply.
                o_found_reg <= pend_valid_reg;
                o_id_reg    <= pend_valid_reg ? pend_id_reg : '0;
                o_dist_reg  <= pend_valid_reg ? pend_dist_reg : 2'd0;
                o_full_reg  <= full_flag_reg;
                o_last_reg  <= 1'b1;
            end
            else
            begin
                o_found_reg <= 1'b1;
                o_id_reg    <= pend_id_reg;
                o_dist_reg  <= pend_dist_reg;
                o_full_reg  <= 1'b0;
                o_last_reg  <= 1'b0;
            end
        end
    end

    assign out_valid  = o_valid_reg;
    assign found      = o_found_reg;
    assign match_id   = o_id_reg;
    assign distance   = o_dist_reg;
    assign table_full = o_full_reg;
    assign last       = o_last_reg;

    // Checks on the sequencer.
    `HBL_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= hbl_pkg::CNT_W'(D), "count")
    `HBL_ASSERT_IMP(a_wr_onehot, clk, rst_n, 1'b1, $onehot0(wr_en), "more than one cell written")
    `HBL_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != hbl_pkg::ST_IDLE, !accept, "busy")
    `HBL_ASSERT_IMP(a_pend_idle, clk, rst_n, state_reg == hbl_pkg::ST_IDLE, !pend_valid_reg, "hit")
    `HBL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(last), "hold")
endmodule

[design/hbl_chain.sv]
// Row of cells through which each probe pattern travels one cell a cycle while the row advances.
`timescale 1ns / 1ps
module hbl_chain (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [hbl_pkg::TABLE_DEPTH-1:0] wr_en,
    input  logic [hbl_pkg::CODE_BITS-1:0]   wr_code,
    input  logic [hbl_pkg::ID_W-1:0]        wr_id,
    input  logic [hbl_pkg::TABLE_DEPTH-1:0] occupied,
    input  logic                            advance,
    input  hbl_pkg::probe_t                 probe,
    output hbl_pkg::probe_t                 tail,
    output logic [hbl_pkg::ID_W-1:0]        ids [hbl_pkg::TABLE_DEPTH]
);
    hbl_pkg::probe_t link [hbl_pkg::TABLE_DEPTH+1];

    assign link[0] = probe;
    assign tail    = link[hbl_pkg::TABLE_DEPTH];

    // Patterns leave the row in issue order, each carrying the hit flags
    // of every cell, so results can be taken in insertion order.
    for (genvar i = 0; i < hbl_pkg::TABLE_DEPTH; i++)
    begin : g_cell
        hbl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en[i]),
            .wr_code   (wr_code),
            .wr_id     (wr_id),
            .occupied  (occupied[i]),
            .advance   (advance),
            .probe_in  (link[i]),
            .probe_out (link[i+1]),
            .id_out    (ids[i])
        );
    end
endmodule

[design/hamming_ball_code_lookup.sv]
// Top level of the Hamming-ball code lookup.
//
// Input channel (in_valid/in_stall) carries command, code and entry_id;
// output channel (out_valid/out_stall) carries the results, each made up
// of found, match_id, distance, table_full and last.
// A clear gives no result. An insert goes through the reply state and
// gives one result; the next transaction is taken once back in idle.
// A query sends 1 + CODE_BITS*(CODE_BITS+1)/2 flip patterns (137 for
// 16-bit codes) into a row of TABLE_DEPTH cells, one pattern a cycle
// while the row advances. Each pattern leaves the row with the hit flags
// of all cells; hits are sent one a cycle in insertion order while the
// receiver does not stall, each pattern with hits holding the row until
// they are sent. A query ends once its final pattern has left the row
// and its hits (up to TABLE_DEPTH) are sent. The last flag marks the
// final result; a query with no hit gives one not-found.
// One item is processed at a time; input stall is high while busy.
// Reset clears the entry count and all control state; the table contents
// are undefined until written.
// A stalled receiver holds the output register and, through it, the row.
`timescale 1ns / 1ps
module hamming_ball_code_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [hbl_pkg::IN_CODE_W-1:0] code,
    input  logic [hbl_pkg::ID_W-1:0]      entry_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [hbl_pkg::ID_W-1:0]      match_id,
    output logic [1:0]                    distance,
    output logic                          table_full,
    output logic                          last
);
    logic [hbl_pkg::TABLE_DEPTH-1:0] wr_en;
    logic [hbl_pkg::TABLE_DEPTH-1:0] occupied;
    logic [hbl_pkg::CODE_BITS-1:0]   wr_code;
    logic [hbl_pkg::ID_W-1:0]        wr_id;
    logic                            advance;
    hbl_pkg::probe_t                 probe;
    hbl_pkg::probe_t                 tail;
    logic [hbl_pkg::ID_W-1:0]        ids [hbl_pkg::TABLE_DEPTH];

    // Sequencer and result path.
    hbl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .code       (code),
        .entry_id   (entry_id),
        .wr_en      (wr_en),
        .wr_code    (wr_code),
        .wr_id      (wr_id),
        .occupied   (occupied),
        .advance    (advance),
        .probe      (probe),
        .tail       (tail),
        .ids        (ids),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .match_id   (match_id),
        .distance   (distance),
        .table_full (table_full),
        .last       (last)
    );

    // Cell chain holding the table.
    hbl_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_code  (wr_code),
        .wr_id    (wr_id),
        .occupied (occupied),
        .advance  (advance),
        .probe    (probe),
        .tail     (tail),
        .ids      (ids)
    );
endmodule

[verif/hamming_ball_code_lookup_test.sv]
// Self-checking testbench for the Hamming-ball code lookup block.
`timescale 1ns / 1ps
module hamming_ball_code_lookup_test;
    typedef struct packed {
        logic [1:0]                command;
        logic [15:0]               code;
        logic [hbl_pkg::ID_W-1:0]  entry_id;
    } lookup_req_t;

    typedef struct packed {
        logic                      found;
        logic [hbl_pkg::ID_W-1:0]  match_id;
        logic [1:0]                distance;
        logic                      table_full;
        logic                      last;
    } lookup_resp_t;

    localparam int IDLE_LIMIT = 20000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                command;
    logic [15:0]               code;
    logic [hbl_pkg::ID_W-1:0]  entry_id;
    logic                      out_valid;
    logic                      out_stall;
    logic                      found;
    logic [hbl_pkg::ID_W-1:0]  match_id;
    logic [1:0]                distance;
    logic                      table_full;
    logic                      last;

    lookup_req_t               pending_reqs[$];
    lookup_resp_t              awaited_resps[$];
    logic [15:0]               table_codes[hbl_pkg::TABLE_DEPTH];
    logic [hbl_pkg::ID_W-1:0]  table_ids[hbl_pkg::TABLE_DEPTH];
    int                        table_count = 0;
    int                        error_count = 0;
    int                        idle_cycles;
    int                        send_gap;
    int                        recv_gap;
    int                        hold_off;
    bit                        hold_start;
    bit                        hold_done;

    hamming_ball_code_lookup u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .code(code), .entry_id(entry_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .match_id(match_id), .distance(distance),
        .table_full(table_full), .last(last)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Random gap length: mostly short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Appends one expected response.
    function automatic void add_resp(lookup_resp_t r);
        awaited_resps.insert(awaited_resps.size(), r);
    endfunction

    // Appends one transaction to be sent.
    function automatic void add_req(lookup_req_t req);
        pending_reqs.insert(pending_reqs.size(), req);
    endfunction

    // Appends every stored entry whose code equals the target.
    function automatic void collect_hits(logic [15:0] target, logic [1:0] hdist);
        lookup_resp_t r;
        for (int i = 0; i < table_count; i++)
        begin
            if (table_codes[i] == target)
            begin
                r = '{1'b1, table_ids[i], hdist, 1'b0, 1'b0};
                add_resp(r);
            end
        end
    endfunction

    // Works out the responses that one accepted transaction causes.
    task automatic predict_lookup(lookup_req_t req);
        lookup_resp_t r;
        int           n0;
        logic [15:0]  once;
        case (hbl_pkg::cmd_t'(req.command))
            hbl_pkg::CMD_CLEAR:
                table_count = 0;
            hbl_pkg::CMD_INSERT:
            begin
                if (table_count >= hbl_pkg::TABLE_DEPTH)
                    r = '{1'b0, '0, 2'd0, 1'b1, 1'b1};
                else
                begin
                    table_codes[table_count] = req.code;
                    table_ids[table_count] = req.entry_id;
                    table_count++;
                    r = '{1'b0, '0, 2'd0, 1'b0, 1'b1};
                end
                add_resp(r);
            end
            hbl_pkg::CMD_QUERY:
            begin
                n0 = awaited_resps.size();
                collect_hits(req.code, 2'd0);
                for (int j = 0; j < hbl_pkg::CODE_BITS; j++)
                begin
                    once = req.code ^ (16'd1 << j);
                    collect_hits(once, 2'd1);
                    for (int k = j + 1; k < hbl_pkg::CODE_BITS; k++)
                        collect_hits(once ^ (16'd1 << k), 2'd2);
                end
                if (awaited_resps.size() == n0)
                    add_resp('{1'b0, '0, 2'd0, 1'b0, 1'b1});
                else
                    awaited_resps[awaited_resps.size() - 1].last = 1'b1;
            end
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(string what);
        $display("ERROR %0t: %s", $time, what);
        error_count++;
    endtask

    // Driver: offers queued transactions with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0;
            code <= '0;
            entry_id <= '0;
            send_gap = 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                predict_lookup('{command, code, entry_id});
                send_gap = pick_gap();
            end
            if (send_gap > 0 || pending_reqs.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                lookup_req_t req;
                req = pending_reqs.pop_front();
                in_valid <= 1'b1;
                command <= req.command;
                code <= req.code;
                entry_id <= req.entry_id;
            end
        end
    end

    // Long receiver hold-off, counted down once started.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_start && !hold_done)
        begin
            hold_off <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // Monitor: checks each accepted response and drives the receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                lookup_resp_t got;
                lookup_resp_t want;
                got = '{found, match_id, distance, table_full, last};
                if (awaited_resps.size() == 0)
                    report_mismatch($sformatf("unexpected response %h", got));
                else
                begin
                    want = awaited_resps.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %b, want %b", got.found, want.found));
                    if (got.match_id !== want.match_id)
                        report_mismatch($sformatf("match_id %h, want %h",
                                                  got.match_id, want.match_id));
                    if (got.distance !== want.distance)
                        report_mismatch($sformatf("distance %0d, want %0d",
                                                  got.distance, want.distance));
                    if (got.table_full !== want.table_full)
                        report_mismatch($sformatf("table_full %b, want %b",
                                                  got.table_full, want.table_full));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
                end
            end
            if (hold_off > 0)
                out_stall <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                recv_gap = pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no accepted transaction on either side, outside the hold-off.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || hold_off > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic lookup_req_t make_req(hbl_pkg::cmd_t c, logic [15:0] cd,
                                             logic [hbl_pkg::ID_W-1:0] id);
        return '{c, cd, id};
    endfunction

    // Random commands on codes near a base, to give many neighbour hits.
    task automatic queue_random_phase(int n_items);
        logic [15:0] base;
        logic [15:0] cd;
        int          r;
        base = 16'($urandom());
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            cd = base;
            if ($urandom_range(0, 1))
                cd ^= 16'd1 << $urandom_range(0, 15);
            if ($urandom_range(0, 1))
                cd ^= 16'd1 << $urandom_range(0, 15);
            if (r < 5)
                cd = 16'($urandom());
            if (r < 2)
                add_req(make_req(hbl_pkg::CMD_CLEAR, 16'($urandom()), 24'($urandom())));
            else if (r < 4)
                add_req(make_req(hbl_pkg::CMD_NONE, 16'($urandom()), 24'($urandom())));
            else if (r < 55)
                add_req(make_req(hbl_pkg::CMD_INSERT, cd, 24'($urandom())));
            else
                add_req(make_req(hbl_pkg::CMD_QUERY, cd, 24'($urandom())));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || awaited_resps.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Stimulus sequencing.
    initial
    begin
        rst_n = 1'b0;
        hold_start = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty query, extremes, each distance, idle command, clear.
        add_req(make_req(hbl_pkg::CMD_QUERY, 16'h0000, '0));
        add_req(make_req(hbl_pkg::CMD_INSERT, 16'h0000, 24'h000000));
        add_req(make_req(hbl_pkg::CMD_INSERT, 16'hFFFF, 24'hFFFFFF));
        add_req(make_req(hbl_pkg::CMD_INSERT, 16'h8000, 24'h123456));
        add_req(make_req(hbl_pkg::CMD_INSERT, 16'hC000, 24'hABCDEF));
        add_req(make_req(hbl_pkg::CMD_INSERT, 16'h0000, 24'h000001));
        add_req(make_req(hbl_pkg::CMD_QUERY, 16'h0000, 24'hFFFFFF));
        add_req(make_req(hbl_pkg::CMD_QUERY, 16'h7FFF, '0));
        add_req(make_req(hbl_pkg::CMD_QUERY, 16'h5A5A, '0));
        add_req(make_req(hbl_pkg::CMD_NONE, 16'hFFFF, 24'hFFFFFF));
        add_req(make_req(hbl_pkg::CMD_CLEAR, 16'hFFFF, 24'hFFFFFF));
        add_req(make_req(hbl_pkg::CMD_QUERY, 16'h0000, '0));
        wait_drained();

        // Fill to overflow with identical codes; the query returns all 64.
        for (int i = 0; i < hbl_pkg::TABLE_DEPTH + 2; i++)
            add_req(make_req(hbl_pkg::CMD_INSERT, 16'h0F0F, 24'(i)));
        add_req(make_req(hbl_pkg::CMD_QUERY, 16'h0F0E, '0));
        wait_drained();

        // Long receiver hold-off while the sender keeps offering.
        add_req(make_req(hbl_pkg::CMD_CLEAR, '0, '0));
        queue_random_phase(40);
        hold_start = 1'b1;
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            add_req(make_req(hbl_pkg::CMD_CLEAR, '0, '0));
            queue_random_phase(30);
            wait_drained();
        end

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[hamming_ball_code_lookup.f]
+incdir+design
design/hbl_pkg.sv
design/hbl_cell.sv
design/hbl_ctrl.sv
design/hbl_chain.sv
design/hamming_ball_code_lookup.sv
verif/hamming_ball_code_lookup_test.sv
